// ===== design/brmc_pkg.sv =====
`timescale 1ns / 1ps

package brmc_pkg;

   // stream widths
   localparam int REQ_W = 104;
   localparam int RSP_W = 64;

   // input field widths
   localparam int ANGLE_W  = 17;
   localparam int RATE_W   = 16;
   localparam int CNT_W    = 16;
   localparam int TARGET_W = 9;

   // register widths
   localparam int OFFSET_W = 8;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 18;
   localparam int CSR_W    = 18;

   // output field widths
   localparam int MOTOR_OUT_W = 11;
   localparam int PWM_W       = 10;

   // bridge full scale
   localparam int PWM_FULL = 1000;
   localparam int MOTOR_W  = $clog2(PWM_FULL + 1) + 1;

   // internal datapath widths
   localparam int BIAS_W  = 10;
   localparam int TBIAS_W = 13;
   localparam int LEAST_W = 18;
   localparam int FILT_W  = 20;
   localparam int INTEG_W = 19;
   localparam int ISUM_W  = 21;
   localparam int BAL_W   = 21;
   localparam int VEL_W   = 28;
   localparam int TRN_W   = 20;
   localparam int BV_W    = 29;
   localparam int MIX_W   = 30;

   // shared multiplier
   localparam int MUL_W  = 26;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W + 1;

   // reciprocal constants for truncating division of magnitudes
   localparam int     SHIFT_112 = 31;
   localparam longint RECIP_112 = ((64'd1 << SHIFT_112) + 111) / 112;
   localparam int     SHIFT_10  = 27;
   localparam longint RECIP_10  = ((64'd1 << SHIFT_10) + 9) / 10;

   // encoder scale: count * 1500 / 448 reduces to count * 375 / 112
   localparam int ENC_SCALE = 375;

   typedef enum logic [2:0] {
      CSR_BALANCE_OFFSET = 3'd0,
      CSR_BALANCE_KP     = 3'd1,
      CSR_BALANCE_KD     = 3'd2,
      CSR_VELOCITY_KP    = 3'd3,
      CSR_VELOCITY_KI    = 3'd4,
      CSR_TURN_KP        = 3'd5,
      CSR_INTEGRAL_LIMIT = 3'd6
   } csr_index_type;

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_TILT0 = 19'h00002,
      ST_TILT1 = 19'h00004,
      ST_TILT2 = 19'h00008,
      ST_TILT3 = 19'h00010,
      ST_SPD0  = 19'h00020,
      ST_SPD1  = 19'h00040,
      ST_SPD2  = 19'h00080,
      ST_SPD3  = 19'h00100,
      ST_SPD4  = 19'h00200,
      ST_SPD5  = 19'h00400,
      ST_SPD6  = 19'h00800,
      ST_SPD7  = 19'h01000,
      ST_VEL0  = 19'h02000,
      ST_VEL1  = 19'h04000,
      ST_VEL2  = 19'h08000,
      ST_MIX0  = 19'h10000,
      ST_MIX1  = 19'h20000,
      ST_OUT   = 19'h40000
   } state_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

endpackage

// ===== design/brmc_mul.sv =====
`timescale 1ns / 1ps

module brmc_mul import brmc_pkg::*; (
   input  logic                      clock,
   input  mul_req_type               mul_req,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // signed product, registered
   assign prod_in = $signed(mul_req.a) * $signed(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/balance_robot_motor_controller_unit.sv =====
`timescale 1ns / 1ps

// Two-wheel balance controller: each item is one control tick (tilt angle, tilt and yaw
// rates, both encoder counts, speed and turn targets) and yields one item with the two
// clamped motor drives and the four H-bridge compare values. A tick runs through tilt PD,
// filtered and integrated speed PI, and proportional turn control on one shared 26x26
// signed multiplier stepped by a one-hot sequencer. The sequencer sets the rate: after
// acceptance req_tready stays low until the sequencer is back in idle, at the same edge at
// which rsp_tvalid rises, so a tick is taken only once the previous one is through. The
// result sits in an output register, so a new item can be taken while the previous result
// is still waiting on rsp_tready; the sequencer only stalls in its last step if that
// register is still full. The filtered speed error and the speed integral persist across
// ticks and are cleared by reset. Gains are signed Q8, except the balance kd, which is
// signed Q12, and csr writes are expected only while the block is idle.
module balance_robot_motor_controller_unit import brmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // tick item
   input  logic             req_tvalid,
   output logic             req_tready,
   // tilt_angle, tilt_rate, yaw_rate, count_left, count_right, speed_target, turn_target
   input  logic [REQ_W-1:0] req_tdata,
   // result item
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // motor_left, motor_right, pwm_left_a, pwm_left_b, pwm_right_a, pwm_right_b
   output logic [RSP_W-1:0] rsp_tdata,
   // register writes
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   // ---------------------------------------------------------------- registers
   logic signed [OFFSET_W-1:0] bal_offset_ff;
   logic signed [GAIN_W-1:0]   bal_kp_ff;
   logic signed [GAIN_W-1:0]   bal_kd_ff;
   logic signed [GAIN_W-1:0]   vel_kp_ff;
   logic signed [GAIN_W-1:0]   vel_ki_ff;
   logic signed [GAIN_W-1:0]   turn_kp_ff;
   logic [LIMIT_W-1:0]         limit_ff;

   state_type                  state_ff, state_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic signed [BIAS_W-1:0]   bias_ff, bias_in;
   logic signed [TBIAS_W-1:0]  tbias_ff, tbias_in;
   logic signed [CNT_W-1:0]    lc_ff, lc_in;
   logic signed [RATE_W-1:0]   trate_ff, trate_in;
   logic signed [TARGET_W-1:0] st_ff, st_in;
   logic signed [LEAST_W-1:0]  least_ff, least_in;
   logic signed [FILT_W-1:0]   half_ff, half_in;
   logic signed [FILT_W-1:0]   filt_ff, filt_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [BAL_W-1:0]    bal_ff, bal_in;
   logic signed [VEL_W-1:0]    vel_ff, vel_in;
   logic signed [TRN_W-1:0]    trn_ff, trn_in;
   logic signed [BV_W-1:0]     bv_ff, bv_in;
   logic signed [MOTOR_W-1:0]  motor_l_ff, motor_l_in;
   logic signed [MOTOR_W-1:0]  motor_r_ff, motor_r_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]           rsp_tdata_ff, rsp_tdata_in;

   mul_req_type                mul_req;
   logic signed [PROD_W-1:0]   prod_ff;

   // shared multiplier, registered product
   brmc_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   // ---------------------------------------------------------------- input fields
   logic                       req_accept;
   logic signed [ANGLE_W-1:0]  f_angle;
   logic signed [RATE_W-1:0]   f_trate;
   logic signed [RATE_W-1:0]   f_yrate;
   logic signed [CNT_W-1:0]    f_cl;
   logic signed [CNT_W-1:0]    f_cr;
   logic signed [TARGET_W-1:0] f_st;
   logic signed [TARGET_W-1:0] f_tt;

   assign req_accept = req_tvalid && req_tready;
   assign f_angle    = $signed(req_tdata[16:0]);
   assign f_trate    = $signed(req_tdata[32:17]);
   assign f_yrate    = $signed(req_tdata[48:33]);
   assign f_cl       = $signed(req_tdata[64:49]);
   assign f_cr       = $signed(req_tdata[80:65]);
   assign f_st       = $signed(req_tdata[89:81]);
   assign f_tt       = $signed(req_tdata[98:90]);

   // tilt bias: trunc((angle - 256 * offset) / 256)
   logic signed [ANGLE_W:0] tilt_diff, tilt_adj;
   assign tilt_diff = (ANGLE_W+1)'(f_angle) - (ANGLE_W+1)'($signed({bal_offset_ff, 8'd0}));
   assign tilt_adj  = tilt_diff + $signed({10'd0, {8{tilt_diff[ANGLE_W]}}});

   // turn bias: trunc((16 * turn_target - yaw_rate) / 16)
   logic signed [RATE_W:0] turn_diff, turn_adj;
   assign turn_diff = (RATE_W+1)'($signed({f_tt, 4'd0})) - (RATE_W+1)'(f_yrate);
   assign turn_adj  = turn_diff + $signed({13'd0, {4{turn_diff[RATE_W]}}});

   // mean count: trunc((left + right) / 2)
   logic signed [CNT_W:0] cnt_sum, cnt_adj;
   assign cnt_sum = (CNT_W+1)'(f_cl) + (CNT_W+1)'(f_cr);
   assign cnt_adj = cnt_sum + $signed({16'd0, cnt_sum[CNT_W]});

   // ---------------------------------------------------------------- datapath helpers
   logic signed [ACC_W-1:0]  prod_sx;
   logic signed [MUL_W-1:0]  prod_lo, prod_lo_abs;
   logic signed [MUL_W-1:0]  acc_lo, acc_lo_abs;
   logic signed [MUL_W-1:0]  lc_wide, lc_abs;
   logic signed [ACC_W-1:0]  acc_rnd12, acc_rnd8, prod_rnd8;
   logic [LEAST_W-2:0]       q_least;
   logic [FILT_W-2:0]        q_filt;
   logic signed [LEAST_W-1:0] q_least_s;
   logic signed [FILT_W-1:0]  q_filt_s;
   logic signed [ISUM_W-1:0]  integ_sum, lim_s;
   logic signed [MIX_W-1:0]   mix_l, mix_r;

   localparam logic signed [MIX_W-1:0] FULL_POS = MIX_W'(PWM_FULL);
   localparam logic signed [MIX_W-1:0] FULL_NEG = -FULL_POS;

   assign prod_sx     = {prod_ff[PROD_W-1], prod_ff};
   assign prod_lo     = $signed(prod_ff[MUL_W-1:0]);
   assign prod_lo_abs = prod_lo[MUL_W-1] ? -prod_lo : prod_lo;
   assign acc_lo      = $signed(acc_ff[MUL_W-1:0]);
   assign acc_lo_abs  = acc_lo[MUL_W-1] ? -acc_lo : acc_lo;
   assign lc_wide     = MUL_W'(lc_ff);
   assign lc_abs      = lc_ff[CNT_W-1] ? -lc_wide : lc_wide;

   // toward-zero rounding offsets for the arithmetic shifts
   assign acc_rnd12 = acc_ff + $signed({{(ACC_W-12){1'b0}}, {12{acc_ff[ACC_W-1]}}});
   assign acc_rnd8  = acc_ff + $signed({{(ACC_W-8){1'b0}}, {8{acc_ff[ACC_W-1]}}});
   assign prod_rnd8 = prod_sx + $signed({{(ACC_W-8){1'b0}}, {8{prod_sx[ACC_W-1]}}});

   // quotients of magnitudes from the reciprocal products
   assign q_least   = prod_ff[SHIFT_112 +: LEAST_W-1];
   assign q_filt    = prod_ff[SHIFT_10 +: FILT_W-1];
   assign q_least_s = $signed({1'b0, q_least});
   assign q_filt_s  = $signed({1'b0, q_filt});

   // integral update with symmetric clamp
   assign integ_sum = ISUM_W'(integ_ff) + ISUM_W'(filt_ff);
   assign lim_s     = $signed({{(ISUM_W-LIMIT_W){1'b0}}, limit_ff});

   // motor mixing
   assign mix_l = MIX_W'(bv_ff) - MIX_W'(trn_ff);
   assign mix_r = MIX_W'(bv_ff) + MIX_W'(trn_ff);

   // ---------------------------------------------------------------- bridge mapping
   localparam logic signed [MOTOR_W-1:0] FULL_M = MOTOR_W'(PWM_FULL);

   logic signed [MOTOR_W-1:0] abs_l, abs_r;
   logic [MOTOR_W-1:0]        pwm_la, pwm_lb, pwm_ra, pwm_rb;
   logic                      both_zero;

   assign abs_l     = motor_l_ff[MOTOR_W-1] ? -motor_l_ff : motor_l_ff;
   assign abs_r     = motor_r_ff[MOTOR_W-1] ? -motor_r_ff : motor_r_ff;
   assign both_zero = (motor_l_ff == '0) && (motor_r_ff == '0);

   always_comb begin
      if (both_zero) begin
         pwm_la = '0;
         pwm_lb = '0;
         pwm_ra = '0;
         pwm_rb = '0;
      end else begin
         if (motor_l_ff[MOTOR_W-1]) begin
            pwm_la = FULL_M;
            pwm_lb = FULL_M - abs_l;
         end else begin
            pwm_la = FULL_M - abs_l;
            pwm_lb = FULL_M;
         end
         if (motor_r_ff[MOTOR_W-1]) begin
            pwm_ra = FULL_M;
            pwm_rb = FULL_M - abs_r;
         end else begin
            pwm_ra = FULL_M - abs_r;
            pwm_rb = FULL_M;
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   logic rsp_free;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      bias_in       = bias_ff;
      tbias_in      = tbias_ff;
      lc_in         = lc_ff;
      trate_in      = trate_ff;
      st_in         = st_ff;
      least_in      = least_ff;
      half_in       = half_ff;
      filt_in       = filt_ff;
      integ_in      = integ_ff;
      bal_in        = bal_ff;
      vel_in        = vel_ff;
      trn_in        = trn_ff;
      bv_in         = bv_ff;
      motor_l_in    = motor_l_ff;
      motor_r_in    = motor_r_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      mul_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               bias_in  = tilt_adj[8 +: BIAS_W];
               tbias_in = turn_adj[4 +: TBIAS_W];
               lc_in    = cnt_adj[1 +: CNT_W];
               trate_in = f_trate;
               st_in    = f_st;
               state_in = ST_TILT0;
            end
         end
         // tilt path: 16 * kp * bias + kd * rate, then / 4096
         ST_TILT0: begin
            mul_req.a = MUL_W'(bal_kp_ff);
            mul_req.b = MUL_W'(bias_ff);
            state_in  = ST_TILT1;
         end
         ST_TILT1: begin
            acc_in    = {prod_sx[ACC_W-5:0], 4'd0};
            mul_req.a = MUL_W'(bal_kd_ff);
            mul_req.b = MUL_W'(trate_ff);
            state_in  = ST_TILT2;
         end
         ST_TILT2: begin
            acc_in    = acc_ff + prod_sx;
            mul_req.a = lc_abs;
            mul_req.b = MUL_W'(ENC_SCALE);
            state_in  = ST_TILT3;
         end
         ST_TILT3: begin
            bal_in    = acc_rnd12[12 +: BAL_W];
            mul_req.a = prod_lo;
            mul_req.b = MUL_W'(RECIP_112);
            state_in  = ST_SPD0;
         end
         // speed path: scaled count minus target, low pass, integrate
         ST_SPD0: begin
            least_in  = (lc_ff[CNT_W-1] ? -q_least_s : q_least_s) - LEAST_W'(st_ff);
            mul_req.a = MUL_W'(filt_ff);
            mul_req.b = MUL_W'(7);
            state_in  = ST_SPD1;
         end
         ST_SPD1: begin
            neg_in    = prod_lo[MUL_W-1];
            mul_req.a = prod_lo_abs;
            mul_req.b = MUL_W'(RECIP_10);
            state_in  = ST_SPD2;
         end
         ST_SPD2: begin
            half_in   = neg_ff ? -q_filt_s : q_filt_s;
            mul_req.a = MUL_W'(least_ff);
            mul_req.b = MUL_W'(3);
            state_in  = ST_SPD3;
         end
         ST_SPD3: begin
            acc_in    = prod_sx;
            mul_req.a = MUL_W'(half_ff);
            mul_req.b = MUL_W'(10);
            state_in  = ST_SPD4;
         end
         ST_SPD4: begin
            acc_in   = acc_ff + prod_sx;
            state_in = ST_SPD5;
         end
         ST_SPD5: begin
            neg_in    = acc_lo[MUL_W-1];
            mul_req.a = acc_lo_abs;
            mul_req.b = MUL_W'(RECIP_10);
            state_in  = ST_SPD6;
         end
         ST_SPD6: begin
            filt_in  = neg_ff ? -q_filt_s : q_filt_s;
            state_in = ST_SPD7;
         end
         ST_SPD7: begin
            priority if (integ_sum < -lim_s) begin
               integ_in = INTEG_W'(-lim_s);
            end else if (integ_sum > lim_s) begin
               integ_in = INTEG_W'(lim_s);
            end else begin
               integ_in = INTEG_W'(integ_sum);
            end
            mul_req.a = MUL_W'(vel_kp_ff);
            mul_req.b = MUL_W'(filt_ff);
            state_in  = ST_VEL0;
         end
         // speed PI sum, then turn product
         ST_VEL0: begin
            acc_in    = prod_sx;
            mul_req.a = MUL_W'(vel_ki_ff);
            mul_req.b = MUL_W'(integ_ff);
            state_in  = ST_VEL1;
         end
         ST_VEL1: begin
            acc_in    = acc_ff + prod_sx;
            mul_req.a = MUL_W'(turn_kp_ff);
            mul_req.b = MUL_W'(tbias_ff);
            state_in  = ST_VEL2;
         end
         ST_VEL2: begin
            vel_in   = acc_rnd8[8 +: VEL_W];
            trn_in   = prod_rnd8[8 +: TRN_W];
            state_in = ST_MIX0;
         end
         ST_MIX0: begin
            bv_in    = BV_W'(bal_ff) + BV_W'(vel_ff);
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            priority if (mix_l < FULL_NEG) begin
               motor_l_in = MOTOR_W'(FULL_NEG);
            end else if (mix_l > FULL_POS) begin
               motor_l_in = MOTOR_W'(FULL_POS);
            end else begin
               motor_l_in = MOTOR_W'(mix_l);
            end
            priority if (mix_r < FULL_NEG) begin
               motor_r_in = MOTOR_W'(FULL_NEG);
            end else if (mix_r > FULL_POS) begin
               motor_r_in = MOTOR_W'(FULL_POS);
            end else begin
               motor_r_in = MOTOR_W'(mix_r);
            end
            state_in = ST_OUT;
         end
         // hold here while the previous result is still unclaimed
         ST_OUT: begin
            if (rsp_free) begin
               rsp_tdata_in  = {2'd0, PWM_W'(pwm_rb), PWM_W'(pwm_ra), PWM_W'(pwm_lb),
                                PWM_W'(pwm_la), MOTOR_OUT_W'(motor_r_ff),
                                MOTOR_OUT_W'(motor_l_ff)};
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         filt_ff       <= '0;
         integ_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         filt_ff       <= filt_in;
         integ_ff      <= integ_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      bias_ff      <= bias_in;
      tbias_ff     <= tbias_in;
      lc_ff        <= lc_in;
      trate_ff     <= trate_in;
      st_ff        <= st_in;
      least_ff     <= least_in;
      half_ff      <= half_in;
      bal_ff       <= bal_in;
      vel_ff       <= vel_in;
      trn_ff       <= trn_in;
      bv_ff        <= bv_in;
      motor_l_ff   <= motor_l_in;
      motor_r_ff   <= motor_r_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bal_offset_ff <= 8'sd6;
         bal_kp_ff     <= 16'sd17920;
         bal_kd_ff     <= -16'sd768;
         vel_kp_ff     <= 16'sd12800;
         vel_ki_ff     <= 16'sd64;
         turn_kp_ff    <= 16'sd10752;
         limit_ff      <= 18'd4000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BALANCE_OFFSET: bal_offset_ff <= $signed(csr_data[OFFSET_W-1:0]);
            CSR_BALANCE_KP:     bal_kp_ff     <= $signed(csr_data[GAIN_W-1:0]);
            CSR_BALANCE_KD:     bal_kd_ff     <= $signed(csr_data[GAIN_W-1:0]);
            CSR_VELOCITY_KP:    vel_kp_ff     <= $signed(csr_data[GAIN_W-1:0]);
            CSR_VELOCITY_KI:    vel_ki_ff     <= $signed(csr_data[GAIN_W-1:0]);
            CSR_TURN_KP:        turn_kp_ff    <= $signed(csr_data[GAIN_W-1:0]);
            CSR_INTEGRAL_LIMIT: limit_ff      <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- checks
   logic signed [ISUM_W-1:0] integ_wide;
   assign integ_wide = ISUM_W'(integ_ff);

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_TILT0))
      else $error("accepted item did not start the tilt sequence");

   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VEL0) |-> ((integ_wide <= lim_s) && (integ_wide >= -lim_s)))
      else $error("speed integral outside its limit after update");

   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == ST_OUT))
      else $error("result overwritten while output still held");

   a_motor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |->
         ((MIX_W'(motor_l_ff) <= FULL_POS) && (MIX_W'(motor_l_ff) >= FULL_NEG) &&
          (MIX_W'(motor_r_ff) <= FULL_POS) && (MIX_W'(motor_r_ff) >= FULL_NEG)))
      else $error("motor drive outside full scale");

endmodule
